/* design/sva_pkg.sv */
package sva_pkg;

  localparam int VOICES = 8;
  localparam int VOICE_W = $clog2(VOICES);
  localparam int BUSY_W = 8;
  localparam int DIST_SHIFT = 20;
  localparam int MAX_ATTEN = 127;
  localparam logic [7:0] FULL_VOLUME = 8'd255;

  typedef struct packed {
    logic [7:0]  sound;
    logic [15:0] origin;
    logic [31:0] frame;
    logic [7:0]  prio;
  } voice_rec_t;

  typedef struct packed {
    logic       done;
    logic       far;
    logic [7:0] vol;
  } dist_res_t;

endpackage

/* design/sva_voice_ram.sv */
module sva_voice_ram
  import sva_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  logic [VOICE_W-1:0] wr_addr,
  input  voice_rec_t         wr_rec,
  input  logic [VOICE_W-1:0] rd_addr,
  output voice_rec_t         rd_rec,
  output logic               rd_used
);

  voice_rec_t mem [VOICES];
  logic [VOICES-1:0] used;
  voice_rec_t rd_q;
  logic rd_used_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_rec;
    end
    rd_q <= mem[rd_addr];
    rd_used_q <= used[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (we) begin
      used[wr_addr] <= 1'b1;
    end
  end

  // entries never written read as zero
  assign rd_rec = rd_used_q ? rd_q : '0;
  assign rd_used = rd_used_q;

endmodule

/* design/sva_dist.sv */
module sva_dist
  import sva_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] origin_x,
  input  logic [31:0] origin_y,
  input  logic [31:0] listener_x,
  input  logic [31:0] listener_y,
  output dist_res_t   res
);

  logic [32:0] ddx;
  logic [32:0] ddy;
  logic [31:0] dx;
  logic [31:0] dy;
  logic v1;
  logic v2;
  logic [31:0] mn;
  logic [32:0] oct_dist;
  logic [12:0] att;
  logic far;
  logic [7:0] vol;
  logic done;

  always_ff @(posedge clk) begin
    ddx <= {origin_x[31], origin_x} - {listener_x[31], listener_x};
    ddy <= {origin_y[31], origin_y} - {listener_y[31], listener_y};
    dx <= ddx[32] ? 32'(-ddx) : ddx[31:0];
    dy <= ddy[32] ? 32'(-ddy) : ddy[31:0];
  end

  always_comb begin
    mn = (dx < dy) ? dx : dy;
    oct_dist = 33'(dx) + 33'(dy) - 33'(mn >> 1);
    att = oct_dist[32:DIST_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      far <= att > 13'(MAX_ATTEN);
      vol <= {7'(MAX_ATTEN) - att[6:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      if (start) begin
        done <= 1'b0;
      end else if (v2) begin
        done <= 1'b1;
      end
    end
  end

  assign res.done = done;
  assign res.far = far;
  assign res.vol = vol;

endmodule

/* design/sound_voice_allocator_core.sv */
// the voice scan reads one record per cycle from the voice ram, and a second pass over
// the ram looks for a voice of lower or equal priority when no voice is free
// requests: one at a time, the next word is taken the cycle after the result moves to
// the output register
// reset: synchronous, clears all voice records to empty, the fallback toggle and the
// sound-disable flag
module sound_voice_allocator_core
  import sva_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  sfx_id,
  input  logic [15:0] origin_handle,
  input  logic        origin_is_listener,
  input  logic [7:0]  sound_priority,
  input  logic        sound_singular,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] listener_x,
  input  logic signed [31:0] listener_y,
  input  logic [31:0] frame_count,
  input  logic [7:0]  voices_busy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  voice,
  output logic [7:0]  sound,
  output logic [7:0]  volume
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_PRIO = 3'd2;
  localparam logic [2:0] ST_TAKE = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  localparam logic [VOICE_W-1:0] LAST_VOICE = VOICE_W'(VOICES - 1);

  logic [2:0] state;
  logic [2:0] state_next;
  logic sound_disabled;
  logic toggle;
  logic toggle_next;
  logic [VOICE_W-1:0] idx;
  logic [VOICE_W-1:0] idx_next;
  logic [VOICE_W-1:0] last_idle;
  logic [VOICE_W-1:0] last_idle_next;
  logic have_idle;
  logic have_idle_next;
  logic [VOICE_W-1:0] chosen;
  logic [VOICE_W-1:0] chosen_next;
  logic [2:0] res_voice;
  logic [2:0] res_voice_next;
  logic [7:0] res_vol;
  logic [7:0] res_vol_next;

  logic [7:0]  req_sound;
  logic [15:0] req_origin;
  logic        req_listener;
  logic [7:0]  req_prio;
  logic        req_singular;
  logic [31:0] req_frame;
  logic [VOICES-1:0] busy_ext;

  logic accept;
  logic out_free;
  logic last;
  logic sound_hit;
  logic idle_hit;
  logic full_vol;
  logic [VOICE_W-1:0] rd_addr;
  logic wr_en;
  voice_rec_t wr_rec;
  voice_rec_t rd_rec;
  logic rd_used;
  dist_res_t dres;

  sva_voice_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .we      (wr_en),
    .wr_addr (chosen),
    .wr_rec  (wr_rec),
    .rd_addr (rd_addr),
    .rd_rec  (rd_rec),
    .rd_used (rd_used)
  );

  sva_dist u_dist (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .listener_x (listener_x),
    .listener_y (listener_y),
    .res        (dres)
  );

  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign last = (idx == LAST_VOICE);
  assign full_vol = (req_origin == 16'd0) || req_listener;

  assign wr_rec.sound = req_sound;
  assign wr_rec.origin = req_origin;
  assign wr_rec.frame = req_frame;
  assign wr_rec.prio = req_prio;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_sound <= sfx_id;
      req_origin <= origin_handle;
      req_listener <= origin_is_listener;
      req_prio <= sound_priority;
      req_singular <= sound_singular;
      req_frame <= frame_count;
      busy_ext <= VOICES'(voices_busy);
    end
  end

  always_comb begin
    sound_hit = rd_used && (rd_rec.sound == req_sound);
    idle_hit = !busy_ext[idx];
    rd_addr = last ? '0 : idx + 1'b1;
    if (state == ST_IDLE) begin
      rd_addr = '0;
    end
  end

  always_comb begin
    state_next = state;
    idx_next = idx;
    last_idle_next = last_idle;
    have_idle_next = have_idle;
    chosen_next = chosen;
    toggle_next = toggle;
    res_voice_next = res_voice;
    res_vol_next = res_vol;
    wr_en = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && !sound_disabled) begin
          state_next = ST_SCAN;
          idx_next = '0;
          have_idle_next = 1'b0;
        end
      end
      ST_SCAN: begin
        if (sound_hit && rd_rec.frame == req_frame) begin
          state_next = ST_IDLE;
        end else if ((sound_hit && req_singular) || rd_rec.origin == req_origin) begin
          chosen_next = idx;
          state_next = ST_TAKE;
        end else begin
          if (idle_hit) begin
            last_idle_next = idx;
            have_idle_next = 1'b1;
          end
          if (last) begin
            idx_next = '0;
            if (have_idle_next) begin
              chosen_next = last_idle_next;
              state_next = ST_TAKE;
            end else begin
              state_next = ST_PRIO;
            end
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      ST_PRIO: begin
        if (rd_rec.prio <= req_prio) begin
          chosen_next = idx;
          state_next = ST_TAKE;
        end else if (last) begin
          if (req_listener) begin
            res_voice_next = 3'(toggle);
            res_vol_next = FULL_VOLUME;
            toggle_next = !toggle;
            state_next = ST_EMIT;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_TAKE: begin
        res_voice_next = 3'(chosen);
        if (full_vol) begin
          wr_en = 1'b1;
          res_vol_next = FULL_VOLUME;
          state_next = ST_EMIT;
        end else if (dres.done) begin
          wr_en = 1'b1;
          res_vol_next = dres.vol;
          state_next = dres.far ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sound_disabled <= 1'b0;
      toggle <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      toggle <= toggle_next;
      if (cfg_we) begin
        sound_disabled <= cfg_wdata;
      end
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    last_idle <= last_idle_next;
    have_idle <= have_idle_next;
    chosen <= chosen_next;
    res_voice <= res_voice_next;
    res_vol <= res_vol_next;
    if (state == ST_EMIT && out_free) begin
      voice <= res_voice;
      sound <= req_sound;
      volume <= res_vol;
    end
  end

endmodule
